### design/pru_pkg.sv
// Shared types and constants of the PID regulator update block.
// Used by the configuration registers, the multiplier, the divider and the top level; no dependencies.
package pru_pkg;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int MUL_WIDTH      = 33;
   localparam int PROD_WIDTH     = 2 * MUL_WIDTH;
   localparam int MAG_WIDTH      = 47;
   localparam int DIV_CNT_WIDTH  = 6;

   localparam logic [15:0]              MIN_STEP  = 16'd7;
   localparam logic [16:0]              ONE_Q16   = 17'h10000;
   localparam logic [DIV_CNT_WIDTH-1:0] DIV_STEPS = 6'd32;

   typedef enum logic [1:0] {
      OP_UPDATE     = 2'd0,
      OP_RESET_STATE = 2'd1,
      OP_CLEAR_PREV  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      REG_GAIN_P         = 3'd0,
      REG_GAIN_I         = 3'd1,
      REG_GAIN_D         = 3'd2,
      REG_INTEGRAL_UPPER = 3'd3,
      REG_INTEGRAL_LOWER = 3'd4,
      REG_DERIV_WEIGHT   = 3'd5,
      REG_INTEGRAL_START = 3'd6
   } reg_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_MUL_P,
      S_MUL_I,
      S_TERM_T,
      S_MUL_TL,
      S_MUL_TH,
      S_INC,
      S_CLAMP,
      S_MUL_D,
      S_TERM_M,
      S_DIV_START,
      S_DIV,
      S_MUL_W1,
      S_MUL_W2,
      S_DSUM,
      S_DNEW,
      S_SUM,
      S_OUT
   } state_type;

   typedef struct packed {
      logic signed [31:0] gain_p;
      logic signed [31:0] gain_i;
      logic signed [31:0] gain_d;
      logic signed [31:0] integral_upper;
      logic signed [31:0] integral_lower;
      logic [16:0]        deriv_weight;
      logic signed [31:0] integral_start;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic overflow;
   } div_status_type;

endpackage

### design/pru_csr.sv
// Configuration registers of the PID regulator update block behind an APB-style port.
// Depends on pru_pkg for the register index codes and the configuration struct.
module pru_csr
   import pru_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index      = reg_index_type'(csr_paddr[4:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_GAIN_P:         cfg_in.gain_p         = csr_pwdata;
            REG_GAIN_I:         cfg_in.gain_i         = csr_pwdata;
            REG_GAIN_D:         cfg_in.gain_d         = csr_pwdata;
            REG_INTEGRAL_UPPER: cfg_in.integral_upper = csr_pwdata;
            REG_INTEGRAL_LOWER: cfg_in.integral_lower = csr_pwdata;
            REG_DERIV_WEIGHT:   cfg_in.deriv_weight   = csr_pwdata[16:0];
            REG_INTEGRAL_START: cfg_in.integral_start = csr_pwdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_GAIN_P:         csr_prdata = cfg_ff.gain_p;
         REG_GAIN_I:         csr_prdata = cfg_ff.gain_i;
         REG_GAIN_D:         csr_prdata = cfg_ff.gain_d;
         REG_INTEGRAL_UPPER: csr_prdata = cfg_ff.integral_upper;
         REG_INTEGRAL_LOWER: csr_prdata = cfg_ff.integral_lower;
         REG_DERIV_WEIGHT:   csr_prdata = {15'b0, cfg_ff.deriv_weight};
         REG_INTEGRAL_START: csr_prdata = cfg_ff.integral_start;
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= '0;
         cfg_ff.gain_i         <= '0;
         cfg_ff.gain_d         <= '0;
         cfg_ff.integral_upper <= '0;
         cfg_ff.integral_lower <= '0;
         cfg_ff.deriv_weight   <= ONE_Q16;
         cfg_ff.integral_start <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/pru_mul.sv
// Shared signed multiplier of the PID regulator update block with a registered product.
// Depends on pru_pkg for the operand and product widths.
module pru_mul
   import pru_pkg::*;
(
   input  logic                         clock,
   input  logic signed [MUL_WIDTH-1:0]  operand_a,
   input  logic signed [MUL_WIDTH-1:0]  operand_b,
   output logic signed [PROD_WIDTH-1:0] product
);

   logic signed [PROD_WIDTH-1:0] product_ff;
   logic signed [PROD_WIDTH-1:0] product_in;

   assign product_in = operand_a * operand_b;
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

### design/pru_div.sv
// Restoring divider of the PID regulator update block, one quotient bit per cycle.
// Depends on pru_pkg for the step count and the status struct.
module pru_div
   import pru_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [62:0]    dividend,
   input  logic [15:0]    divisor,
   output logic [31:0]    quotient,
   output div_status_type status
);

   logic [15:0]              rem_ff;
   logic [15:0]              rem_in;
   logic [31:0]              shreg_ff;
   logic [31:0]              shreg_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff;
   logic [DIV_CNT_WIDTH-1:0] cnt_in;
   logic                     busy_ff;
   logic                     busy_in;
   logic                     done_ff;
   logic                     done_in;
   logic                     ovf_ff;
   logic                     ovf_in;
   logic [16:0]              rem_ext;
   logic [16:0]              rem_sub;
   logic                     fits;

   assign rem_ext = {rem_ff, shreg_ff[31]};
   assign rem_sub = rem_ext - {1'b0, divisor};
   assign fits    = rem_ext >= {1'b0, divisor};

   always_comb begin
      rem_in   = rem_ff;
      shreg_in = shreg_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      ovf_in   = ovf_ff;
      if (start) begin
         ovf_in   = dividend[62:32] >= {15'b0, divisor};
         rem_in   = dividend[47:32];
         shreg_in = dividend[31:0];
         cnt_in   = DIV_STEPS;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? rem_sub[15:0] : rem_ext[15:0];
         shreg_in = {shreg_ff[30:0], fits};
         cnt_in   = cnt_ff - 1'b1;
         done_in  = cnt_ff == 6'd1;
         busy_in  = cnt_ff != 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shreg_ff <= shreg_in;
      ovf_ff   <= ovf_in;
   end

   assign quotient        = shreg_ff;
   assign status.busy     = busy_ff;
   assign status.done     = done_ff;
   assign status.overflow = ovf_ff;

endmodule

### design/pid_regulator_update.sv
// PID regulator update block: top level with the sequencer and the regulator state.
// Depends on pru_pkg, pru_csr, pru_mul and pru_div.
//
// Usage: the req channel carries one transaction per command (op, error_value,
// time_step). An update with a time step of at least 7 yields one rsp transaction
// with the saturated P+I+D drive value; a shorter step yields a zero drive value
// with step_skipped set. Reset-state and clear-previous commands only change the
// regulator state and yield no rsp transaction.
// A full update runs through the sequencer steps from acceptance to rsp_valid; no new
// command is taken before the sequencer is idle again. Its length is set by the single
// shared 33x33 multiplier, used seven times in sequence, and by the 32-step divider for
// the derivative. A skipped step goes from acceptance straight to the output step; the
// other commands change the regulator state on acceptance. req_stall is high while an
// update is in work. The finished result waits in the output register while rsp_stall
// is high, and the sequencer holds its last step until that register is free. A
// synchronous reset clears the regulator state, resets the configuration registers and
// drops any transaction in work. Configuration must be written over the csr port only
// while no command is in work; the block does not enforce this.
module pid_regulator_update
   import pru_pkg::*;
#(
   parameter int FRACTION_BITS = 16
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_op,
   input  logic signed [31:0]        req_error_value,
   input  logic [15:0]               req_time_step,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [31:0]        rsp_drive_value,
   output logic                      rsp_step_skipped,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   function automatic logic [31:0] mag32(input logic signed [31:0] x);
      logic [31:0] neg;
      neg = 32'(-x);
      return x[31] ? neg : x;
   endfunction

   function automatic logic signed [31:0] clamp_value(input logic signed [48:0] v,
                                                      input logic signed [31:0] lower,
                                                      input logic signed [31:0] upper);
      logic signed [48:0] lower_ext;
      logic signed [48:0] upper_ext;
      lower_ext = {{17{lower[31]}}, lower};
      upper_ext = {{17{upper[31]}}, upper};
      if (v < lower_ext) begin
         return lower;
      end else if (v > upper_ext) begin
         return upper;
      end
      return v[31:0];
   endfunction

   cfg_type        cfg;
   div_status_type div_status;
   logic [31:0]    div_quotient;
   logic           div_start;
   logic signed [MUL_WIDTH-1:0]  mul_a;
   logic signed [MUL_WIDTH-1:0]  mul_b;
   logic signed [PROD_WIDTH-1:0] prod;

   state_type state_ff;
   state_type state_in;
   logic signed [31:0] e_ff;
   logic signed [31:0] e_in;
   logic [15:0]        dt_ff;
   logic [15:0]        dt_in;
   logic signed [31:0] prev_ff;
   logic signed [31:0] prev_in;
   logic signed [31:0] integral_ff;
   logic signed [31:0] integral_in;
   logic signed [31:0] deriv_ff;
   logic signed [31:0] deriv_in;
   logic signed [47:0] p_ff;
   logic signed [47:0] p_in;
   logic [MAG_WIDTH-1:0] t_mag_ff;
   logic [MAG_WIDTH-1:0] t_mag_in;
   logic               t_neg_ff;
   logic               t_neg_in;
   logic signed [PROD_WIDTH-1:0] acc_ff;
   logic signed [PROD_WIDTH-1:0] acc_in;
   logic signed [48:0] isum_ff;
   logic signed [48:0] isum_in;
   logic [MAG_WIDTH-1:0] m_mag_ff;
   logic [MAG_WIDTH-1:0] m_mag_in;
   logic               m_neg_ff;
   logic               m_neg_in;
   logic signed [31:0] newd_ff;
   logic signed [31:0] newd_in;
   logic signed [49:0] dsum_ff;
   logic signed [49:0] dsum_in;
   logic signed [31:0] res_drive_ff;
   logic signed [31:0] res_drive_in;
   logic               res_skip_ff;
   logic               res_skip_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic signed [31:0] rsp_drive_ff;
   logic signed [31:0] rsp_drive_in;
   logic               rsp_skip_ff;
   logic               rsp_skip_in;

   logic                  accept;
   logic                  out_free;
   op_type                op;
   logic [PROD_WIDTH-1:0] prod_shift;
   logic [MAG_WIDTH-1:0]  prod_sat;
   logic signed [32:0]    diff;
   logic signed [32:0]    diff_neg;
   logic [31:0]           diff_mag;
   logic [16:0]           weight_eff;
   logic [16:0]           weight_rest;
   logic [PROD_WIDTH-1:0] inc_total;
   logic [MAG_WIDTH-1:0]  inc_mag;
   logic signed [47:0]    inc_signed;
   logic signed [49:0]    dsum_adj;
   logic signed [49:0]    total;
   logic                  quot_big;

   pru_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pru_mul u_mul (
      .clock     (clock),
      .operand_a (mul_a),
      .operand_b (mul_b),
      .product   (prod)
   );

   pru_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({m_mag_ff, 16'b0}),
      .divisor  (dt_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign op       = op_type'(req_op);

   assign prod_shift  = $unsigned(prod) >> FRACTION_BITS;
   assign prod_sat    = (|prod_shift[PROD_WIDTH-1:MAG_WIDTH]) ? {MAG_WIDTH{1'b1}}
                                                              : prod_shift[MAG_WIDTH-1:0];
   assign diff        = {e_ff[31], e_ff} - {prev_ff[31], prev_ff};
   assign diff_neg    = -diff;
   assign diff_mag    = diff[32] ? diff_neg[31:0] : diff[31:0];
   assign weight_eff  = cfg.deriv_weight[16] ? ONE_Q16 : cfg.deriv_weight;
   assign weight_rest = ONE_Q16 - weight_eff;
   assign inc_total   = $unsigned(acc_ff) + {prod[33:0], 32'b0};
   assign inc_mag     = inc_total[62:16];
   assign inc_signed  = t_neg_ff ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
   assign dsum_adj    = dsum_ff[49] ? dsum_ff + 50'sd65535 : dsum_ff;
   assign total       = {{2{p_ff[47]}}, p_ff} + {{18{integral_ff[31]}}, integral_ff}
                        + {{18{deriv_ff[31]}}, deriv_ff};
   assign quot_big    = div_status.overflow || div_quotient[31];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && op == OP_UPDATE) begin
               state_in = (req_time_step < MIN_STEP) ? S_OUT : S_MUL_P;
            end
         end
         S_MUL_P:     state_in = S_MUL_I;
         S_MUL_I:     state_in = S_TERM_T;
         S_TERM_T:    state_in = S_MUL_TL;
         S_MUL_TL:    state_in = S_MUL_TH;
         S_MUL_TH:    state_in = S_INC;
         S_INC:       state_in = S_CLAMP;
         S_CLAMP:     state_in = S_MUL_D;
         S_MUL_D:     state_in = S_TERM_M;
         S_TERM_M:    state_in = S_DIV_START;
         S_DIV_START: state_in = S_DIV;
         S_DIV: begin
            if (div_status.done) begin
               state_in = S_MUL_W1;
            end
         end
         S_MUL_W1:    state_in = S_MUL_W2;
         S_MUL_W2:    state_in = S_DSUM;
         S_DSUM:      state_in = S_DNEW;
         S_DNEW:      state_in = S_SUM;
         S_SUM:       state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_stall = state_ff != S_IDLE;
      div_start = state_ff == S_DIV_START;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         S_MUL_P: begin
            mul_a = {1'b0, mag32(cfg.gain_p)};
            mul_b = {1'b0, mag32(e_ff)};
         end
         S_MUL_I: begin
            mul_a = {1'b0, mag32(cfg.gain_i)};
            mul_b = {1'b0, mag32(e_ff)};
         end
         S_MUL_TL: begin
            mul_a = {1'b0, t_mag_ff[31:0]};
            mul_b = {17'b0, dt_ff};
         end
         S_MUL_TH: begin
            mul_a = {18'b0, t_mag_ff[46:32]};
            mul_b = {17'b0, dt_ff};
         end
         S_MUL_D: begin
            mul_a = {1'b0, mag32(cfg.gain_d)};
            mul_b = {1'b0, diff_mag};
         end
         S_MUL_W1: begin
            mul_a = {16'b0, weight_eff};
            mul_b = {newd_ff[31], newd_ff};
         end
         S_MUL_W2: begin
            mul_a = {16'b0, weight_rest};
            mul_b = {deriv_ff[31], deriv_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      e_in         = e_ff;
      dt_in        = dt_ff;
      prev_in      = prev_ff;
      integral_in  = integral_ff;
      deriv_in     = deriv_ff;
      p_in         = p_ff;
      t_mag_in     = t_mag_ff;
      t_neg_in     = t_neg_ff;
      acc_in       = acc_ff;
      isum_in      = isum_ff;
      m_mag_in     = m_mag_ff;
      m_neg_in     = m_neg_ff;
      newd_in      = newd_ff;
      dsum_in      = dsum_ff;
      res_drive_in = res_drive_ff;
      res_skip_in  = res_skip_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_drive_in = rsp_drive_ff;
      rsp_skip_in  = rsp_skip_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (op)
                  OP_UPDATE: begin
                     e_in  = req_error_value;
                     dt_in = req_time_step;
                     if (req_time_step < MIN_STEP) begin
                        prev_in      = req_error_value;
                        res_drive_in = '0;
                        res_skip_in  = 1'b1;
                     end
                  end
                  OP_RESET_STATE: begin
                     prev_in     = '0;
                     deriv_in    = '0;
                     integral_in = clamp_value({{17{cfg.integral_start[31]}},
                                                cfg.integral_start},
                                               cfg.integral_lower, cfg.integral_upper);
                  end
                  OP_CLEAR_PREV: prev_in = '0;
                  default:       prev_in = prev_ff;
               endcase
            end
         end
         S_MUL_I: begin
            p_in = (cfg.gain_p[31] ^ e_ff[31]) ? -$signed({1'b0, prod_sat})
                                               : $signed({1'b0, prod_sat});
         end
         S_TERM_T: begin
            t_mag_in = prod_sat;
            t_neg_in = cfg.gain_i[31] ^ e_ff[31];
         end
         S_MUL_TH: acc_in = prod;
         S_INC: begin
            isum_in = {{17{integral_ff[31]}}, integral_ff} + {inc_signed[47], inc_signed};
         end
         S_CLAMP: integral_in = clamp_value(isum_ff, cfg.integral_lower, cfg.integral_upper);
         S_TERM_M: begin
            m_mag_in = prod_sat;
            m_neg_in = cfg.gain_d[31] ^ diff[32];
         end
         S_DIV: begin
            if (div_status.done) begin
               if (quot_big) begin
                  newd_in = m_neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
               end else begin
                  newd_in = m_neg_ff ? -$signed(div_quotient) : $signed(div_quotient);
               end
            end
         end
         S_MUL_W2: acc_in = prod;
         S_DSUM:   dsum_in = $signed(acc_ff[49:0]) + $signed(prod[49:0]);
         S_DNEW:   deriv_in = dsum_adj[47:16];
         S_SUM: begin
            prev_in     = e_ff;
            res_skip_in = 1'b0;
            if (total > 50'sh0_0000_7FFF_FFFF) begin
               res_drive_in = 32'sh7FFF_FFFF;
            end else if (total < -50'sh0_0000_8000_0000) begin
               res_drive_in = 32'sh8000_0000;
            end else begin
               res_drive_in = total[31:0];
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = res_drive_ff;
               rsp_skip_in  = res_skip_ff;
            end
         end
         default: begin
            rsp_drive_in = rsp_drive_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         integral_ff  <= '0;
         deriv_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         integral_ff  <= integral_in;
         deriv_ff     <= deriv_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff         <= e_in;
      dt_ff        <= dt_in;
      p_ff         <= p_in;
      t_mag_ff     <= t_mag_in;
      t_neg_ff     <= t_neg_in;
      acc_ff       <= acc_in;
      isum_ff      <= isum_in;
      m_mag_ff     <= m_mag_in;
      m_neg_ff     <= m_neg_in;
      newd_ff      <= newd_in;
      dsum_ff      <= dsum_in;
      res_drive_ff <= res_drive_in;
      res_skip_ff  <= res_skip_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_skip_ff  <= rsp_skip_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_value  = rsp_drive_ff;
   assign rsp_step_skipped = rsp_skip_ff;

`ifndef NO_ASSERTIONS
   a_skip_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_skipped |-> rsp_drive_value == 32'sd0)
      else $error("Skipped step transaction carries a nonzero drive value.");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("Result register loaded outside the output step.");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == S_DIV)
      else $error("Divider finished while the sequencer was not waiting for it.");

   a_idle_div_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !div_status.busy)
      else $error("Divider still busy while the sequencer is idle.");
`endif

endmodule
